>>> rtl/core/two_sample_ks_statistic_assert.svh
// assertion macros for the two-sample ks statistic block
// no dependencies; included by modules that check their own logic
`ifndef TWO_SAMPLE_KS_STATISTIC_ASSERT_SVH
`define TWO_SAMPLE_KS_STATISTIC_ASSERT_SVH

// implication checked on every clock edge outside reset
`define KS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define KS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/ks_pkg.sv
// shared constants for the two-sample ks statistic block
// no dependencies
package ks_pkg;
   localparam int MaxSamples  = 1024;
   localparam int SampleWidth = 32;
   localparam int InWidth     = 32;
   localparam int GapWidth    = 21;
   localparam int CountWidth  = 11;

   // set tags
   localparam logic TagA = 1'b0;
   localparam logic TagB = 1'b1;
endpackage

>>> rtl/core/ks_front.sv
// front end: takes samples, counts per set, drops items for full sets, queues inserts
// depends on ks_pkg
module ks_front #(
   parameter int MAX_SAMPLES  = ks_pkg::MaxSamples,
   parameter int SAMPLE_WIDTH = ks_pkg::SampleWidth,
   parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [ks_pkg::InWidth-1:0] sample_value,
   input  logic                    which_set,
   input  logic                    last,
   input  logic                    deq,
   output logic                    q_valid,
   output logic [SAMPLE_WIDTH:0]   q_key,
   output logic                    q_tag,
   output logic                    q_last,
   output logic                    q_ins,
   output logic [CW-1:0]           cnt_a,
   output logic [CW-1:0]           cnt_b,
   output logic                    q_full
);
   import ks_pkg::*;

   localparam int QD = 2;
   localparam int EW = SAMPLE_WIDTH + 4;

   logic [EW-1:0] fifo_ff [QD];
   logic [0:0]    wp_ff, rp_ff;
   logic [1:0]    used_ff;
   logic [CW-1:0] cnt_a_ff, cnt_b_ff;
   logic [SAMPLE_WIDTH-1:0] raw;
   logic [SAMPLE_WIDTH-1:0] biased;
   logic          ok;
   logic          push;

   // take the low bits (sign-extended when wider) and flip the sign so unsigned order follows signed order
   always_comb begin
      raw = '0;
      for (int b = 0; b < SAMPLE_WIDTH; b++) begin
         raw[b] = (b < InWidth) ? sample_value[b] : sample_value[InWidth-1];
      end
      biased = raw ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   end

   assign ok = (which_set == TagA) ? (cnt_a_ff != CW'(MAX_SAMPLES))
                                   : (cnt_b_ff != CW'(MAX_SAMPLES));
   assign push = take && (ok || last);

   // counters, cleared after a last item
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else if (take) begin
         if (last) begin
            cnt_a_ff <= '0;
            cnt_b_ff <= '0;
         end else if (ok && which_set == TagA) begin
            cnt_a_ff <= cnt_a_ff + 1'b1;
         end else if (ok) begin
            cnt_b_ff <= cnt_b_ff + 1'b1;
         end
      end
   end

   // counts including the item being accepted, handed with a last item
   logic [CW-1:0] fa, fb;
   assign fa = cnt_a_ff + CW'(ok && which_set == TagA);
   assign fb = cnt_b_ff + CW'(ok && which_set == TagB);

   // small queue to the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         used_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (deq) begin
            rp_ff <= rp_ff + 1'b1;
         end
         used_ff <= used_ff + 2'(push) - 2'(deq);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= {{1'b0, biased}, which_set, last, ok};
      end
   end

   // count snapshot for the walk
   always_ff @(posedge clock) begin
      if (take && last) begin
         cnt_a <= fa;
         cnt_b <= fb;
      end
   end

   assign q_valid = used_ff != 2'd0;
   assign q_full  = used_ff == 2'(QD);
   assign q_key   = fifo_ff[rp_ff][EW-1:3];
   assign q_tag   = fifo_ff[rp_ff][2];
   assign q_last  = fifo_ff[rp_ff][1];
   assign q_ins   = fifo_ff[rp_ff][0];
endmodule

>>> rtl/core/ks_back.sv
// back end: insertion into a sorted memory, then a walk over the merged order
// depends on ks_pkg and the assertion macro header
`include "two_sample_ks_statistic_assert.svh"
module ks_back #(
   parameter int MAX_SAMPLES  = ks_pkg::MaxSamples,
   parameter int SAMPLE_WIDTH = ks_pkg::SampleWidth,
   parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [SAMPLE_WIDTH:0] q_key,
   input  logic                  q_tag,
   input  logic                  q_last,
   input  logic                  q_ins,
   input  logic [CW-1:0]         cnt_a,
   input  logic [CW-1:0]         cnt_b,
   output logic                  deq,
   output logic                  walking,
   output logic                  rsp_strobe,
   output logic [ks_pkg::GapWidth-1:0]   rsp_max_gap_numerator,
   output logic [ks_pkg::CountWidth-1:0] rsp_count_a,
   output logic [ks_pkg::CountWidth-1:0] rsp_count_b,
   output logic                  rsp_empty_set
);
   import ks_pkg::*;

   localparam int DEPTH = 2 * MAX_SAMPLES;
   localparam int AW = $clog2(DEPTH);
   localparam int TW = $clog2(DEPTH + 1);
   localparam int PW = 2 * CW + 1;
   localparam int KW = SAMPLE_WIDTH + 1;
   localparam int MW = SAMPLE_WIDTH + 2;

   typedef enum logic [2:0] {S_LOAD, S_SHIFT, S_PLACE, S_WSTART, S_WALK, S_DONE} state_type;

   // sorted store: each entry holds key and tag
   logic [MW-1:0]         mem_ff [DEPTH];
   logic [MW-1:0]         rd_data_ff;
   logic [MW-1:0]         ins_ff;
   logic                  ins_last_ff;
   logic [TW-1:0]         pos_ff;
   logic [TW-1:0]         total_ff;
   state_type             state_ff;
   logic [TW-1:0]         k_ff;
   logic [CW-1:0]         i_ff, j_ff;
   logic [PW-1:0]         best_ff;
   logic [CW-1:0]         na_ff, nb_ff;
   logic [KW-1:0]         prev_key_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [MW-1:0]         wr_data;
   logic [KW-1:0]         rd_key;
   logic                  rd_tag;
   logic                  above;
   state_type             after_ins;
   logic [PW-1:0]         x, y, d;

   assign deq = q_valid && state_ff == S_LOAD;
   assign walking = state_ff == S_WSTART || state_ff == S_WALK || state_ff == S_DONE;

   assign rd_key = rd_data_ff[MW-1:1];
   assign rd_tag = rd_data_ff[0];
   // stored entry sorts above the one being inserted
   assign above  = rd_key > ins_ff[MW-1:1];

   // memory port control: scan down from the top during insertion, up during the walk
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(pos_ff);
      wr_data = ins_ff;
      rd_addr = AW'(k_ff + 1'b1);
      case (state_ff)
         S_LOAD: begin
            rd_addr = AW'(total_ff - 1'b1);
         end
         S_SHIFT: begin
            wr_en = 1'b1;
            if (above) begin
               wr_data = rd_data_ff;
            end
            rd_addr = AW'(pos_ff - 2'd2);
         end
         S_PLACE: begin
            wr_en = 1'b1;
         end
         S_WSTART: begin
            rd_addr = '0;
         end
         default: begin
            rd_addr = AW'(k_ff + 1'b1);
         end
      endcase
   end

   // one write when enabled and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // where to go once an insertion is complete
   always_comb begin
      if (!ins_last_ff) begin
         after_ins = S_LOAD;
      end else if (na_ff == '0 || nb_ff == '0) begin
         after_ins = S_DONE;
      end else begin
         after_ins = S_WSTART;
      end
   end

   // gap at a group boundary, counts through the previous entry
   assign x = PW'(i_ff) * PW'(nb_ff);
   assign y = PW'(j_ff) * PW'(na_ff);
   assign d = (x >= y) ? x - y : y - x;

   // control: load with insertion, walk one entry per cycle, report
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         total_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            S_LOAD: begin
               if (deq) begin
                  ins_ff <= {q_key, q_tag};
                  ins_last_ff <= q_last;
                  pos_ff <= total_ff;
                  if (q_last) begin
                     na_ff <= cnt_a;
                     nb_ff <= cnt_b;
                     k_ff <= '0;
                     i_ff <= '0;
                     j_ff <= '0;
                     best_ff <= '0;
                  end
                  if (q_ins && total_ff < TW'(DEPTH)) begin
                     state_ff <= (total_ff == '0) ? S_PLACE : S_SHIFT;
                  end else if (q_last) begin
                     state_ff <= (cnt_a == '0 || cnt_b == '0) ? S_DONE : S_WSTART;
                  end
               end
            end
            S_SHIFT: begin
               if (above) begin
                  pos_ff <= pos_ff - 1'b1;
                  if (pos_ff == TW'(1)) begin
                     state_ff <= S_PLACE;
                  end
               end else begin
                  total_ff <= total_ff + 1'b1;
                  state_ff <= after_ins;
               end
            end
            S_PLACE: begin
               total_ff <= total_ff + 1'b1;
               state_ff <= after_ins;
            end
            S_WSTART: begin
               state_ff <= S_WALK;
            end
            S_WALK: begin
               // a change of value closes the previous group
               if ((k_ff == '0 || rd_key != prev_key_ff) && d > best_ff) begin
                  best_ff <= d;
               end
               if (rd_tag == TagB) begin
                  j_ff <= j_ff + 1'b1;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
               prev_key_ff <= rd_key;
               k_ff <= k_ff + 1'b1;
               // the final group always closes at zero gap
               if (k_ff + 1'b1 == total_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_strobe <= 1'b1;
               rsp_max_gap_numerator <= GapWidth'(best_ff);
               rsp_count_a <= CountWidth'(na_ff);
               rsp_count_b <= CountWidth'(nb_ff);
               rsp_empty_set <= (na_ff == '0) || (nb_ff == '0);
               total_ff <= '0;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   `KS_ASSERT_IMPL(a_total_bound, clock, reset, 1'b1, total_ff <= TW'(DEPTH))
   `KS_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_strobe)
   `KS_ASSERT_IMPL(a_no_deq_walk, clock, reset, state_ff != S_LOAD, !deq)
   `KS_ASSERT_IMPL(a_shift_slot, clock, reset, state_ff == S_SHIFT, pos_ff != '0)
endmodule

>>> rtl/core/two_sample_ks_statistic.sv
// two-sample ks statistic: each sample is inserted into a sorted memory by moving each
// stored sample above it up one slot, then a walk of one entry per cycle follows the last item.
// busy holds from a last transfer to its result; else the 2-entry queue takes one a cycle until full.
// synchronous active-high reset clears counts, queue and the walk sequencer.
module two_sample_ks_statistic #(
   parameter int MAX_SAMPLES  = ks_pkg::MaxSamples,
   parameter int SAMPLE_WIDTH = ks_pkg::SampleWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [ks_pkg::InWidth-1:0] req_sample_value,
   input  logic        req_which_set,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [ks_pkg::GapWidth-1:0]   rsp_max_gap_numerator,
   output logic [ks_pkg::CountWidth-1:0] rsp_count_a,
   output logic [ks_pkg::CountWidth-1:0] rsp_count_b,
   output logic        rsp_empty_set
);
   import ks_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);

   logic q_valid, q_tag, q_last, q_ins, q_full, deq, walking;
   logic [SAMPLE_WIDTH:0] q_key;
   logic [CW-1:0] cnt_a, cnt_b;
   logic lastq_ff;

   // hold off while the queue is full, a last item is pending or the walk runs
   always_ff @(posedge clock) begin
      if (reset) begin
         lastq_ff <= 1'b0;
      end else if (start && !busy && req_last) begin
         lastq_ff <= 1'b1;
      end else if (rsp_strobe) begin
         lastq_ff <= 1'b0;
      end
   end
   assign busy = q_full || walking || lastq_ff;

   ks_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH), .CW(CW)) u_front (
      .clock, .reset, .take(start && !busy), .sample_value(req_sample_value),
      .which_set(req_which_set), .last(req_last), .deq, .q_valid, .q_key,
      .q_tag, .q_last, .q_ins, .cnt_a, .cnt_b, .q_full
   );

   ks_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH), .CW(CW)) u_back (
      .clock, .reset, .q_valid, .q_key, .q_tag, .q_last, .q_ins, .cnt_a, .cnt_b,
      .deq, .walking, .rsp_strobe, .rsp_max_gap_numerator, .rsp_count_a,
      .rsp_count_b, .rsp_empty_set
   );
endmodule

>>> verif/testbench.sv
// self-checking testbench for the two-sample ks statistic block
// depends on ks_pkg and two_sample_ks_statistic; predicts each statistic from a sorted copy
module testbench;
   import ks_pkg::*;

   localparam int WatchdogLimit = 40000;
   localparam int DrainCycles   = 2 * MaxSamples + 50;

   typedef struct {
      logic [GapWidth-1:0]   gap;
      logic [CountWidth-1:0] cnt_a;
      logic [CountWidth-1:0] cnt_b;
      logic                  empty;
   } ks_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [InWidth-1:0]    req_sample_value;
   logic                  req_which_set;
   logic                  req_last;
   logic                  rsp_strobe;
   logic [GapWidth-1:0]   rsp_max_gap_numerator;
   logic [CountWidth-1:0] rsp_count_a;
   logic [CountWidth-1:0] rsp_count_b;
   logic                  rsp_empty_set;

   // predictor state: merged sorted samples and the two counts
   longint        merged_key[$];
   logic          merged_tag[$];
   int            held_a;
   int            held_b;
   ks_result_type pending_stats[$];
   int            error_count;
   int            items_sent;
   int            idle_cycles;

   two_sample_ks_statistic dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_sample_value      (req_sample_value),
      .req_which_set         (req_which_set),
      .req_last              (req_last),
      .rsp_strobe            (rsp_strobe),
      .rsp_max_gap_numerator (rsp_max_gap_numerator),
      .rsp_count_a           (rsp_count_a),
      .rsp_count_b           (rsp_count_b),
      .rsp_empty_set         (rsp_empty_set)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // insert one sample into the sorted copy, then compute the statistic on a last flag
   task automatic predict_sample(input logic [InWidth-1:0] value, input logic tag,
                                 input logic last);
      longint        key;
      int            pos;
      longint        i;
      longint        j;
      longint        best;
      longint        d;
      int            k;
      ks_result_type res;
      key = longint'($signed(value));
      if ((tag == TagA && held_a < MaxSamples) || (tag == TagB && held_b < MaxSamples)) begin
         pos = merged_key.size();
         while (pos > 0 && merged_key[pos-1] > key) pos--;
         merged_key.insert(pos, key);
         merged_tag.insert(pos, tag);
         if (tag == TagA) held_a++;
         else held_b++;
      end
      if (last) begin
         best = 0;
         if (held_a != 0 && held_b != 0) begin
            i = 0;
            j = 0;
            k = 0;
            // each run of equal values is one step of the walk
            while (k < merged_key.size()) begin
               key = merged_key[k];
               while (k < merged_key.size() && merged_key[k] == key) begin
                  if (merged_tag[k] == TagB) j++;
                  else i++;
                  k++;
               end
               d = i * held_b - j * held_a;
               if (d < 0) d = -d;
               if (d > best) best = d;
            end
         end
         res.gap   = best[GapWidth-1:0];
         res.cnt_a = held_a[CountWidth-1:0];
         res.cnt_b = held_b[CountWidth-1:0];
         res.empty = (held_a == 0 || held_b == 0);
         pending_stats.insert(pending_stats.size(), res);
         merged_key.delete();
         merged_tag.delete();
         held_a = 0;
         held_b = 0;
      end
   endtask

   // one transfer on the input channel, after a random gap
   task automatic send_sample(input logic [InWidth-1:0] value, input logic tag,
                              input logic last);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_sample_value <= value;
      req_which_set    <= tag;
      req_last         <= last;
      do @(posedge clock); while (busy);
      predict_sample(value, tag, last);
      items_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            ks_result_type want;
            want = pending_stats.pop_front();
            if (rsp_max_gap_numerator !== want.gap)
               report_mismatch("max_gap_numerator", rsp_max_gap_numerator, want.gap);
            if (rsp_count_a !== want.cnt_a) report_mismatch("count_a", rsp_count_a, want.cnt_a);
            if (rsp_count_b !== want.cnt_b) report_mismatch("count_b", rsp_count_b, want.cnt_b);
            if (rsp_empty_set !== want.empty)
               report_mismatch("empty_set", rsp_empty_set, want.empty);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_empty_sets();
      send_sample(32'h0001_0000, TagA, 1'b1);
      send_sample(32'hFFFF_0000, TagB, 1'b1);
      send_sample(32'h0000_0000, TagA, 1'b0);
      send_sample(32'h0000_0001, TagA, 1'b1);
   endtask

   task automatic test_extremes_and_ties();
      send_sample(32'h8000_0000, TagA, 1'b0);
      send_sample(32'h7FFF_FFFF, TagB, 1'b1);
      send_sample(32'h7FFF_FFFF, TagA, 1'b0);
      send_sample(32'h8000_0000, TagB, 1'b1);
      // ties across and within sets
      send_sample(32'h0000_0005, TagA, 1'b0);
      send_sample(32'h0000_0005, TagB, 1'b0);
      send_sample(32'h0000_0005, TagA, 1'b0);
      send_sample(32'hFFFF_FFFF, TagB, 1'b0);
      send_sample(32'hFFFF_FFFF, TagB, 1'b0);
      send_sample(32'h0000_0005, TagB, 1'b1);
      send_sample(32'h5555_5555, TagA, 1'b0);
      send_sample(32'hAAAA_AAAA, TagB, 1'b1);
   endtask

   // fill set a past its limit, drops must not count
   task automatic test_set_full();
      for (int n = 0; n < MaxSamples + 4; n++)
         send_sample($urandom_range(0, 15), TagA, 1'b0);
      send_sample(32'h0000_0003, TagB, 1'b0);
      send_sample(32'h0000_0009, TagA, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_sets();
      int  set_len;
      int  narrow;
      logic [InWidth-1:0] value;
      while (items_sent < 1800) begin
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
         narrow  = $urandom_range(0, 2);
         for (int n = 0; n < set_len; n++) begin
            if (narrow == 0) value = $urandom_range(0, 8) - 4;
            else value = $urandom();
            send_sample(value, 1'($urandom_range(0, 1)), n == set_len - 1);
         end
         if ($urandom_range(0, 7) == 0) wait_for_results();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_sample_value <= '0;
      req_which_set    <= 1'b0;
      req_last         <= 1'b0;
      error_count = 0;
      items_sent  = 0;
      held_a      = 0;
      held_b      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_sets();
      test_extremes_and_ties();
      test_set_full();
      test_random_sets();
      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> two_sample_ks_statistic.f
+incdir+rtl/core
rtl/core/ks_pkg.sv
rtl/core/ks_front.sv
rtl/core/ks_back.sv
rtl/core/two_sample_ks_statistic.sv
verif/testbench.sv
